[design/swerve_module_kinematics_assert.svh]
// Assertion macros for the swerve module kinematics block.
`ifndef SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SWMK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check that a condition implies a second one in the same cycle.
`define SWMK_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`else
`define SWMK_ASSERT(label, prop, msg)
`define SWMK_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

[design/swmk_pkg.sv]
// Shared constants, widths and tables of the swerve module kinematics block.
package swmk_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int NUM_MODULES   = 4;

   localparam int CMD_W     = 16;
   localparam int TRIM_W    = 9;
   localparam int SPEED_W   = 8;
   localparam int ANGLE_W   = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_D = 2'd3;

   localparam int HALF_ROOT_Q30 = 759250125;  // sqrt(1/2) in Q.30
   localparam int HR_SHIFT      = 30;
   localparam int MAG_EXTRA     = 8;
   localparam int ANG_FRAC      = 16;
   localparam int CORDIC_SCALE  = 20;
   localparam int CORDIC_STEPS  = 23;
   localparam int SQRT_STEPS    = 25;
   localparam int QUOT_W        = 7;
   localparam int SPEED_MAX     = 127;

   localparam int P_W    = 47;   // turn times half root
   localparam int VEC_W  = 18;   // wheel vector component
   localparam int PROD_W = 32;   // one squared component
   localparam int SQ_W   = 33;   // squared magnitude
   localparam int RAD_W  = 2 * SQRT_STEPS;
   localparam int REM_W  = SQRT_STEPS + 2;
   localparam int MAG_W  = SQRT_STEPS;
   localparam int CX_W   = 40;   // rotator operands
   localparam int ANG_W  = 25;   // angle in Q.16 degrees
   localparam int NUM_W  = 32;   // 127 times magnitude
   localparam int ATAN_W = 22;

   // Lane sign pattern: x is negated on modules two and three,
   // y on modules one and two.
   function automatic logic lane_neg_x(input int k);
      return (k >= 2);
   endfunction

   function automatic logic lane_neg_y(input int k);
      return (k == 1) || (k == 2);
   endfunction

   // atan(2^-i) in Q.16 degrees.
   function automatic logic [ATAN_W-1:0] atan_q16(input int i);
      logic [ATAN_W-1:0] v;
      case (i)
         0:  v = 22'd2949120;
         1:  v = 22'd1740967;
         2:  v = 22'd919879;
         3:  v = 22'd466945;
         4:  v = 22'd234379;
         5:  v = 22'd117304;
         6:  v = 22'd58666;
         7:  v = 22'd29335;
         8:  v = 22'd14668;
         9:  v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[design/swerve_module_kinematics.sv]
// Swerve drive inverse kinematics: four wheel speeds and steering angles per command.
//
// One command beat (strafe, forward, turn in signed Q1.FRAC_BITS) yields one result beat
// with a drive speed (-127..127) and a steering angle in degrees plus trim for each of the
// four modules. The block is a 40-stage pipeline and takes a new beat every cycle while not
// stalled; results are shown from a register. The depth is set by the
// bit-per-stage square root (25 stages, the rotator's 23 steps run beside it) and the
// 7-stage restoring divider that scales speeds by the largest wheel magnitude. rsp_stall
// freezes the whole pipe, including the result register, and is reflected on req_stall
// only while a result is waiting; bubbles keep flowing otherwise. Trim registers are
// written through the csr port, which is always ready; write them only while the pipe is
// empty. There is no clearing pass after reset.
module swerve_module_kinematics #(
   parameter int FRAC_BITS = swmk_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [swmk_pkg::CMD_W-1:0]     req_strafe_cmd,
   input  logic signed [swmk_pkg::CMD_W-1:0]     req_forward_cmd,
   input  logic signed [swmk_pkg::CMD_W-1:0]     req_turn_cmd,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [swmk_pkg::SPEED_W-1:0]   rsp_drive_speed_a,
   output logic signed [swmk_pkg::SPEED_W-1:0]   rsp_drive_speed_b,
   output logic signed [swmk_pkg::SPEED_W-1:0]   rsp_drive_speed_c,
   output logic signed [swmk_pkg::SPEED_W-1:0]   rsp_drive_speed_d,
   output logic signed [swmk_pkg::ANGLE_W-1:0]   rsp_steer_angle_a,
   output logic signed [swmk_pkg::ANGLE_W-1:0]   rsp_steer_angle_b,
   output logic signed [swmk_pkg::ANGLE_W-1:0]   rsp_steer_angle_c,
   output logic signed [swmk_pkg::ANGLE_W-1:0]   rsp_steer_angle_d,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swmk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic signed [swmk_pkg::TRIM_W-1:0]    csr_data
);

`include "swerve_module_kinematics_assert.svh"

   localparam int NL      = swmk_pkg::NUM_MODULES;
   localparam int CMD_W   = swmk_pkg::CMD_W;
   localparam int P_W     = swmk_pkg::P_W;
   localparam int VEC_W   = swmk_pkg::VEC_W;
   localparam int PROD_W  = swmk_pkg::PROD_W;
   localparam int SQ_W    = swmk_pkg::SQ_W;
   localparam int RAD_W   = swmk_pkg::RAD_W;
   localparam int REM_W   = swmk_pkg::REM_W;
   localparam int MAG_W   = swmk_pkg::MAG_W;
   localparam int CX_W    = swmk_pkg::CX_W;
   localparam int ANG_W   = swmk_pkg::ANG_W;
   localparam int NUM_W   = swmk_pkg::NUM_W;
   localparam int QUOT_W  = swmk_pkg::QUOT_W;
   localparam int NSQ     = swmk_pkg::SQRT_STEPS;
   localparam int NCR     = swmk_pkg::CORDIC_STEPS;
   localparam int AF      = swmk_pkg::ANG_FRAC;
   localparam int AOUT_W  = ANG_W + 1;
   localparam int ALT_SHIFT = FRAC_BITS + swmk_pkg::MAG_EXTRA;

   localparam logic signed [P_W-1:0] ROUND_HALF =
      P_W'(64'd1 << (swmk_pkg::HR_SHIFT - 1));
   localparam logic [63:0] UNIT_SQ  = 64'd1 << (2 * FRAC_BITS);
   // 400*sq < 2^(2F) is the same as sq < ceil(2^(2F)/400)
   localparam logic [63:0] DEAD_LIM = (UNIT_SQ + 64'd399) / 64'd400;
   localparam logic signed [ANG_W-1:0] ANG_P90 = ANG_W'(90 * (1 << AF));

   // Angle source chosen at the rotator entry.
   localparam logic [1:0] ASEL_CORDIC = 2'd0;
   localparam logic [1:0] ASEL_ZERO   = 2'd1;
   localparam logic [1:0] ASEL_POS90  = 2'd2;
   localparam logic [1:0] ASEL_NEG90  = 2'd3;

   // Pipeline advance: freeze everything while a result waits on a stalled sink.
   logic en;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- trim registers ----------------
   logic signed [swmk_pkg::TRIM_W-1:0] trim_ff [NL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NL; k++) trim_ff[k] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            swmk_pkg::CSR_TRIM_A: trim_ff[0] <= csr_data;
            swmk_pkg::CSR_TRIM_B: trim_ff[1] <= csr_data;
            swmk_pkg::CSR_TRIM_C: trim_ff[2] <= csr_data;
            swmk_pkg::CSR_TRIM_D: trim_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage A: capture command ----------------
   logic                     a_v_ff;
   logic signed [CMD_W-1:0]  a_x_ff, a_y_ff, a_r_ff;

   // ---------------- stage B: turn times sqrt(1/2) ----------------
   logic                     b_v_ff;
   logic signed [CMD_W-1:0]  b_x_ff, b_y_ff;
   logic signed [P_W-1:0]    b_p_ff, b_p_in;

   assign b_p_in = P_W'(a_r_ff) * $signed(P_W'(swmk_pkg::HALF_ROOT_Q30));

   // ---------------- stage C: round, form wheel vectors, fold ----------------
   logic                     c_v_ff;
   logic signed [P_W-1:0]    c_hr_full;
   logic signed [VEC_W-1:0]  c_hr;
   logic signed [VEC_W-1:0]  c_vx_in [NL];
   logic signed [VEC_W-1:0]  c_vy_in [NL];
   logic                     c_neg_in [NL];
   logic signed [VEC_W-1:0]  c_vx_ff [NL];
   logic signed [VEC_W-1:0]  c_vy_ff [NL];
   logic                     c_neg_ff [NL];

   always_comb begin
      // round half away from zero
      if (!b_p_ff[P_W-1]) begin
         c_hr_full = (b_p_ff + ROUND_HALF) >>> swmk_pkg::HR_SHIFT;
      end else begin
         c_hr_full = -((-b_p_ff + ROUND_HALF) >>> swmk_pkg::HR_SHIFT);
      end
      c_hr = c_hr_full[VEC_W-1:0];
      for (int k = 0; k < NL; k++) begin
         c_vx_in[k] = VEC_W'(b_x_ff) + (swmk_pkg::lane_neg_x(k) ? -c_hr : c_hr);
         c_vy_in[k] = VEC_W'(b_y_ff) + (swmk_pkg::lane_neg_y(k) ? -c_hr : c_hr);
         c_neg_in[k] = c_vy_in[k][VEC_W-1];
         // fold: point the wheel forward and reverse the drive
         if (c_neg_in[k]) begin
            c_vx_in[k] = -c_vx_in[k];
            c_vy_in[k] = -c_vy_in[k];
         end
      end
   end

   // ---------------- stage D: squares ----------------
   logic                     d_v_ff;
   logic [VEC_W-2:0]         d_ax [NL];
   logic [VEC_W-2:0]         d_ay [NL];
   logic [PROD_W-1:0]        d_vx2_in [NL];
   logic [PROD_W-1:0]        d_vy2_in [NL];
   logic [PROD_W-1:0]        d_vx2_ff [NL];
   logic [PROD_W-1:0]        d_vy2_ff [NL];
   logic signed [VEC_W-1:0]  d_vx_ff [NL];
   logic signed [VEC_W-1:0]  d_vy_ff [NL];
   logic                     d_neg_ff [NL];

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         d_ax[k] = c_vx_ff[k][VEC_W-1] ? (VEC_W-1)'(-c_vx_ff[k]) : c_vx_ff[k][VEC_W-2:0];
         d_ay[k] = c_vy_ff[k][VEC_W-2:0];
         d_vx2_in[k] = PROD_W'(d_ax[k] * d_ax[k]);
         d_vy2_in[k] = PROD_W'(d_ay[k] * d_ay[k]);
      end
   end

   // ---------------- stages E and I1..I25: root and rotator ----------------
   // Index 0 is stage E: sum of squares, dead band, angle source, operand load.
   logic [NSQ:0]                it_v_ff;
   logic [RAD_W-1:0]            it_rad_in  [0:NSQ][NL];
   logic [REM_W-1:0]            it_rem_in  [0:NSQ][NL];
   logic [MAG_W-1:0]            it_root_in [0:NSQ][NL];
   logic signed [CX_W-1:0]      it_cx_in   [0:NSQ][NL];
   logic signed [CX_W-1:0]      it_cy_in   [0:NSQ][NL];
   logic signed [ANG_W-1:0]     it_cz_in   [0:NSQ][NL];
   logic [RAD_W-1:0]            it_rad_ff  [0:NSQ][NL];
   logic [REM_W-1:0]            it_rem_ff  [0:NSQ][NL];
   logic [MAG_W-1:0]            it_root_ff [0:NSQ][NL];
   logic signed [CX_W-1:0]      it_cx_ff   [0:NSQ][NL];
   logic signed [CX_W-1:0]      it_cy_ff   [0:NSQ][NL];
   logic signed [ANG_W-1:0]     it_cz_ff   [0:NSQ][NL];
   logic [1:0]                  it_asel_ff [0:NSQ][NL];
   logic                        it_neg_ff  [0:NSQ][NL];
   logic                        it_big_ff  [0:NSQ][NL];
   logic [SQ_W-1:0]             e_sq [NL];
   logic [1:0]                  e_asel_in [NL];
   logic                        e_big_in  [NL];

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         e_sq[k] = SQ_W'(d_vx2_ff[k]) + SQ_W'(d_vy2_ff[k]);
         e_big_in[k] = 64'(e_sq[k]) > UNIT_SQ;
         if (64'(e_sq[k]) < DEAD_LIM) begin
            e_asel_in[k] = ASEL_ZERO;
         end else if (d_vy_ff[k] == '0) begin
            e_asel_in[k] = d_vx_ff[k][VEC_W-1] ? ASEL_NEG90 : ASEL_POS90;
         end else if (d_vx_ff[k] == '0) begin
            e_asel_in[k] = ASEL_ZERO;
         end else begin
            e_asel_in[k] = ASEL_CORDIC;
         end
         it_rad_in[0][k]  = {1'b0, e_sq[k], {(RAD_W-SQ_W-1){1'b0}}};
         it_rem_in[0][k]  = '0;
         it_root_in[0][k] = '0;
         it_cx_in[0][k]   = CX_W'(d_vy_ff[k]) <<< swmk_pkg::CORDIC_SCALE;
         it_cy_in[0][k]   = CX_W'(d_vx_ff[k]) <<< swmk_pkg::CORDIC_SCALE;
         it_cz_in[0][k]   = '0;
      end
   end

   for (genvar j = 1; j <= NSQ; j++) begin : g_iter
      for (genvar k = 0; k < NL; k++) begin : g_lane
         logic [REM_W-1:0]       rem_t;
         logic [REM_W-1:0]       trial;

         // one result bit of the square root
         always_comb begin
            rem_t = {it_rem_ff[j-1][k][REM_W-3:0], it_rad_ff[j-1][k][RAD_W-1 -: 2]};
            trial = {it_root_ff[j-1][k], 2'b01};
            it_rad_in[j][k] = it_rad_ff[j-1][k] << 2;
            if (rem_t >= trial) begin
               it_rem_in[j][k]  = rem_t - trial;
               it_root_in[j][k] = {it_root_ff[j-1][k][MAG_W-2:0], 1'b1};
            end else begin
               it_rem_in[j][k]  = rem_t;
               it_root_in[j][k] = {it_root_ff[j-1][k][MAG_W-2:0], 1'b0};
            end
         end

         if (j - 1 < NCR) begin : g_rot
            logic signed [CX_W-1:0]  xs, ys;
            logic signed [ANG_W-1:0] at;

            // one vectoring rotation, floor shifts
            always_comb begin
               xs = it_cx_ff[j-1][k] >>> (j - 1);
               ys = it_cy_ff[j-1][k] >>> (j - 1);
               at = $signed(ANG_W'(swmk_pkg::atan_q16(j - 1)));
               if (!it_cy_ff[j-1][k][CX_W-1]) begin
                  it_cx_in[j][k] = it_cx_ff[j-1][k] + ys;
                  it_cy_in[j][k] = it_cy_ff[j-1][k] - xs;
                  it_cz_in[j][k] = it_cz_ff[j-1][k] + at;
               end else begin
                  it_cx_in[j][k] = it_cx_ff[j-1][k] - ys;
                  it_cy_in[j][k] = it_cy_ff[j-1][k] + xs;
                  it_cz_in[j][k] = it_cz_ff[j-1][k] - at;
               end
            end
         end else begin : g_hold
            // rotator done: hold the angle while the root finishes
            always_comb begin
               it_cx_in[j][k] = it_cx_ff[j-1][k];
               it_cy_in[j][k] = it_cy_ff[j-1][k];
               it_cz_in[j][k] = it_cz_ff[j-1][k];
            end
         end
      end
   end

   // ---------------- stage F: angle select, 127*mag, first max level ----------------
   logic                     f_v_ff;
   logic [MAG_W-1:0]         f_mag [NL];
   logic [NUM_W-1:0]         f_num_in [NL];
   logic [NUM_W-1:0]         f_alt_full [NL];
   logic [QUOT_W-1:0]        f_alt_in [NL];
   logic signed [ANG_W-1:0]  f_ang_in [NL];
   logic [MAG_W-1:0]         f_m01_in, f_m23_in;
   logic                     f_norm_in;
   logic [NUM_W-1:0]         f_num_ff [NL];
   logic [QUOT_W-1:0]        f_alt_ff [NL];
   logic signed [ANG_W-1:0]  f_ang_ff [NL];
   logic                     f_neg_ff [NL];
   logic [MAG_W-1:0]         f_m01_ff, f_m23_ff;
   logic                     f_norm_ff;

   always_comb begin
      f_norm_in = 1'b0;
      for (int k = 0; k < NL; k++) begin
         f_mag[k] = it_root_ff[NSQ][k];
         f_num_in[k] = (NUM_W'(f_mag[k]) << QUOT_W) - NUM_W'(f_mag[k]);
         f_alt_full[k] = f_num_in[k] >> ALT_SHIFT;
         f_alt_in[k] = (f_alt_full[k] > NUM_W'(swmk_pkg::SPEED_MAX)) ?
                       QUOT_W'(swmk_pkg::SPEED_MAX) : f_alt_full[k][QUOT_W-1:0];
         f_norm_in = f_norm_in | it_big_ff[NSQ][k];
         case (it_asel_ff[NSQ][k])
            ASEL_CORDIC: f_ang_in[k] = it_cz_ff[NSQ][k];
            ASEL_POS90:  f_ang_in[k] = ANG_P90;
            ASEL_NEG90:  f_ang_in[k] = -ANG_P90;
            default:     f_ang_in[k] = '0;
         endcase
      end
      f_m01_in = (f_mag[0] > f_mag[1]) ? f_mag[0] : f_mag[1];
      f_m23_in = (f_mag[2] > f_mag[3]) ? f_mag[2] : f_mag[3];
   end

   // ---------------- stages G and V1..V7: largest magnitude, divide ----------------
   // Index 0 is stage G; quotient fits 7 bits since mag never exceeds the max.
   logic [QUOT_W:0]          dv_v_ff;
   logic [MAG_W-1:0]         g_max_in;
   logic [NUM_W-1:0]         dv_rem_in [0:QUOT_W][NL];
   logic [QUOT_W-1:0]        dv_q_in   [0:QUOT_W][NL];
   logic [NUM_W-1:0]         dv_rem_ff [0:QUOT_W][NL];
   logic [QUOT_W-1:0]        dv_q_ff   [0:QUOT_W][NL];
   logic [QUOT_W-1:0]        dv_alt_ff [0:QUOT_W][NL];
   logic signed [ANG_W-1:0]  dv_ang_ff [0:QUOT_W][NL];
   logic                     dv_neg_ff [0:QUOT_W][NL];
   logic [MAG_W-1:0]         dv_max_ff [0:QUOT_W];
   logic                     dv_norm_ff [0:QUOT_W];

   always_comb begin
      g_max_in = (f_m01_ff > f_m23_ff) ? f_m01_ff : f_m23_ff;
      for (int k = 0; k < NL; k++) begin
         dv_rem_in[0][k] = f_num_ff[k];
         dv_q_in[0][k]   = '0;
      end
   end

   for (genvar j = 1; j <= QUOT_W; j++) begin : g_div
      for (genvar k = 0; k < NL; k++) begin : g_lane
         logic [NUM_W-1:0] trial;

         // restoring step for quotient bit QUOT_W-j
         always_comb begin
            trial = NUM_W'(dv_max_ff[j-1]) << (QUOT_W - j);
            dv_q_in[j][k] = dv_q_ff[j-1][k];
            if (dv_rem_ff[j-1][k] >= trial) begin
               dv_rem_in[j][k] = dv_rem_ff[j-1][k] - trial;
               dv_q_in[j][k][QUOT_W-j] = 1'b1;
            end else begin
               dv_rem_in[j][k] = dv_rem_ff[j-1][k];
            end
         end
      end
   end

   // ---------------- stage H: sign, trim, truncate ----------------
   logic [QUOT_W-1:0]          h_mag [NL];
   logic signed [AOUT_W-1:0]   h_sum [NL];
   logic signed [AOUT_W-1:0]   h_trunc [NL];
   logic signed [swmk_pkg::SPEED_W-1:0] h_speed_in [NL];
   logic signed [swmk_pkg::ANGLE_W-1:0] h_angle_in [NL];
   logic signed [swmk_pkg::SPEED_W-1:0] h_speed_ff [NL];
   logic signed [swmk_pkg::ANGLE_W-1:0] h_angle_ff [NL];

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         h_mag[k] = dv_norm_ff[QUOT_W] ? dv_q_ff[QUOT_W][k] : dv_alt_ff[QUOT_W][k];
         h_speed_in[k] = dv_neg_ff[QUOT_W][k] ? -$signed(swmk_pkg::SPEED_W'(h_mag[k])) :
                                                  $signed(swmk_pkg::SPEED_W'(h_mag[k]));
         h_sum[k] = AOUT_W'(dv_ang_ff[QUOT_W][k]) + (AOUT_W'(trim_ff[k]) <<< AF);
         // truncate toward zero
         if (!h_sum[k][AOUT_W-1]) begin
            h_trunc[k] = h_sum[k] >>> AF;
         end else begin
            h_trunc[k] = -((-h_sum[k]) >>> AF);
         end
         h_angle_in[k] = h_trunc[k][swmk_pkg::ANGLE_W-1:0];
      end
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         d_v_ff       <= 1'b0;
         it_v_ff      <= '0;
         f_v_ff       <= 1'b0;
         dv_v_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_v_ff       <= req_valid;
         b_v_ff       <= a_v_ff;
         c_v_ff       <= b_v_ff;
         d_v_ff       <= c_v_ff;
         it_v_ff      <= {it_v_ff[NSQ-1:0], d_v_ff};
         f_v_ff       <= it_v_ff[NSQ];
         dv_v_ff      <= {dv_v_ff[QUOT_W-1:0], f_v_ff};
         rsp_valid_ff <= dv_v_ff[QUOT_W];
      end
   end

   // ---------------- payload registers: advance together ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff <= req_strafe_cmd;
         a_y_ff <= req_forward_cmd;
         a_r_ff <= req_turn_cmd;
         b_x_ff <= a_x_ff;
         b_y_ff <= a_y_ff;
         b_p_ff <= b_p_in;
         for (int k = 0; k < NL; k++) begin
            c_vx_ff[k]  <= c_vx_in[k];
            c_vy_ff[k]  <= c_vy_in[k];
            c_neg_ff[k] <= c_neg_in[k];
            d_vx2_ff[k] <= d_vx2_in[k];
            d_vy2_ff[k] <= d_vy2_in[k];
            d_vx_ff[k]  <= c_vx_ff[k];
            d_vy_ff[k]  <= c_vy_ff[k];
            d_neg_ff[k] <= c_neg_ff[k];
            it_asel_ff[0][k] <= e_asel_in[k];
            it_neg_ff[0][k]  <= d_neg_ff[k];
            it_big_ff[0][k]  <= e_big_in[k];
         end
         for (int j = 0; j <= NSQ; j++) begin
            for (int k = 0; k < NL; k++) begin
               it_rad_ff[j][k]  <= it_rad_in[j][k];
               it_rem_ff[j][k]  <= it_rem_in[j][k];
               it_root_ff[j][k] <= it_root_in[j][k];
               it_cx_ff[j][k]   <= it_cx_in[j][k];
               it_cy_ff[j][k]   <= it_cy_in[j][k];
               it_cz_ff[j][k]   <= it_cz_in[j][k];
            end
         end
         for (int j = 1; j <= NSQ; j++) begin
            for (int k = 0; k < NL; k++) begin
               it_asel_ff[j][k] <= it_asel_ff[j-1][k];
               it_neg_ff[j][k]  <= it_neg_ff[j-1][k];
               it_big_ff[j][k]  <= it_big_ff[j-1][k];
            end
         end
         for (int k = 0; k < NL; k++) begin
            f_num_ff[k] <= f_num_in[k];
            f_alt_ff[k] <= f_alt_in[k];
            f_ang_ff[k] <= f_ang_in[k];
            f_neg_ff[k] <= it_neg_ff[NSQ][k];
         end
         f_m01_ff  <= f_m01_in;
         f_m23_ff  <= f_m23_in;
         f_norm_ff <= f_norm_in;
         dv_max_ff[0]  <= g_max_in;
         dv_norm_ff[0] <= f_norm_ff;
         for (int k = 0; k < NL; k++) begin
            dv_alt_ff[0][k] <= f_alt_ff[k];
            dv_ang_ff[0][k] <= f_ang_ff[k];
            dv_neg_ff[0][k] <= f_neg_ff[k];
         end
         for (int j = 0; j <= QUOT_W; j++) begin
            for (int k = 0; k < NL; k++) begin
               dv_rem_ff[j][k] <= dv_rem_in[j][k];
               dv_q_ff[j][k]   <= dv_q_in[j][k];
            end
         end
         for (int j = 1; j <= QUOT_W; j++) begin
            dv_max_ff[j]  <= dv_max_ff[j-1];
            dv_norm_ff[j] <= dv_norm_ff[j-1];
            for (int k = 0; k < NL; k++) begin
               dv_alt_ff[j][k] <= dv_alt_ff[j-1][k];
               dv_ang_ff[j][k] <= dv_ang_ff[j-1][k];
               dv_neg_ff[j][k] <= dv_neg_ff[j-1][k];
            end
         end
         for (int k = 0; k < NL; k++) begin
            h_speed_ff[k] <= h_speed_in[k];
            h_angle_ff[k] <= h_angle_in[k];
         end
      end
   end

   assign rsp_drive_speed_a = h_speed_ff[0];
   assign rsp_drive_speed_b = h_speed_ff[1];
   assign rsp_drive_speed_c = h_speed_ff[2];
   assign rsp_drive_speed_d = h_speed_ff[3];
   assign rsp_steer_angle_a = h_angle_ff[0];
   assign rsp_steer_angle_b = h_angle_ff[1];
   assign rsp_steer_angle_c = h_angle_ff[2];
   assign rsp_steer_angle_d = h_angle_ff[3];

   // ---------------- assertions ----------------
   `SWMK_ASSERT(a_accept_enters, (req_valid && !req_stall) |=> a_v_ff, "accepted beat lost at entry")
   `SWMK_ASSERT(a_pipe_frozen, (rsp_valid_ff && rsp_stall) |=> ($stable(it_v_ff) && $stable(dv_v_ff)), "pipe moved under stall")
   `SWMK_ASSERT_IMPL(a_div_rem_a, dv_v_ff[QUOT_W] && dv_norm_ff[QUOT_W], dv_rem_ff[QUOT_W][0] < NUM_W'(dv_max_ff[QUOT_W]), "divider remainder not below divisor")
   `SWMK_ASSERT_IMPL(a_div_rem_d, dv_v_ff[QUOT_W] && dv_norm_ff[QUOT_W], dv_rem_ff[QUOT_W][3] < NUM_W'(dv_max_ff[QUOT_W]), "divider remainder not below divisor")

endmodule

[test/swmk_checker.sv]
// Scoreboard for the swerve kinematics block: predicts each command and checks each result.
`timescale 1ns / 1ps
module swmk_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [swmk_pkg::CMD_W-1:0]   req_strafe_cmd,
   input  logic signed [swmk_pkg::CMD_W-1:0]   req_forward_cmd,
   input  logic signed [swmk_pkg::CMD_W-1:0]   req_turn_cmd,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [swmk_pkg::SPEED_W-1:0] rsp_drive_speed_a,
   input  logic signed [swmk_pkg::SPEED_W-1:0] rsp_drive_speed_b,
   input  logic signed [swmk_pkg::SPEED_W-1:0] rsp_drive_speed_c,
   input  logic signed [swmk_pkg::SPEED_W-1:0] rsp_drive_speed_d,
   input  logic signed [swmk_pkg::ANGLE_W-1:0] rsp_steer_angle_a,
   input  logic signed [swmk_pkg::ANGLE_W-1:0] rsp_steer_angle_b,
   input  logic signed [swmk_pkg::ANGLE_W-1:0] rsp_steer_angle_c,
   input  logic signed [swmk_pkg::ANGLE_W-1:0] rsp_steer_angle_d,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [swmk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic signed [swmk_pkg::TRIM_W-1:0]  csr_data,
   output int                                  pending,
   output int                                  errors
);

   localparam int FB            = swmk_pkg::FRAC_BITS_DEF;
   localparam int NUM_MODULES   = swmk_pkg::NUM_MODULES;
   localparam int SPEED_W       = swmk_pkg::SPEED_W;
   localparam int ANGLE_W       = swmk_pkg::ANGLE_W;
   localparam int TRIM_W        = swmk_pkg::TRIM_W;
   localparam int CORDIC_STEPS  = swmk_pkg::CORDIC_STEPS;
   localparam int CORDIC_SCALE  = swmk_pkg::CORDIC_SCALE;
   localparam int ANG_FRAC      = swmk_pkg::ANG_FRAC;
   localparam int HALF_ROOT_Q30 = swmk_pkg::HALF_ROOT_Q30;
   localparam int HR_SHIFT      = swmk_pkg::HR_SHIFT;
   localparam int MAG_EXTRA     = swmk_pkg::MAG_EXTRA;
   localparam int SPEED_MAX     = swmk_pkg::SPEED_MAX;

   typedef struct {
      logic signed [SPEED_W-1:0] speed [NUM_MODULES];
      logic signed [ANGLE_W-1:0] angle [NUM_MODULES];
   } wheel_cmd_type;

   localparam longint ARCTAN_DEG [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

   logic signed [TRIM_W-1:0] trim_deg [NUM_MODULES];
   wheel_cmd_type            wheel_q [$];

   function automatic longint root_floor(input longint unsigned a);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (a >= res + bitv) begin
            a   = a - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   // atan2(num, den) in Q.16 degrees with den >= 0
   function automatic longint heading_q16(input longint num, input longint den);
      longint x, y, z, xs, ys;
      z = 0;
      if (den == 0) return (num > 0) ? (longint'(90) << ANG_FRAC) :
                           (num < 0) ? -(longint'(90) << ANG_FRAC) : 0;
      if (num == 0) return 0;
      x = den <<< CORDIC_SCALE;
      y = num <<< CORDIC_SCALE;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARCTAN_DEG[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARCTAN_DEG[i];
         end
      end
      return z;
   endfunction

   function automatic wheel_cmd_type solve_wheels(input longint x, input longint y,
                                                  input longint r);
      wheel_cmd_type res;
      longint p, hr, vx, vy, sq, maxsq, maxmag, s, a;
      longint mg [NUM_MODULES];
      longint ang [NUM_MODULES];
      bit     neg [NUM_MODULES];
      bit     norm;
      maxsq  = 0;
      maxmag = 0;
      p = r * HALF_ROOT_Q30;
      if (p >= 0) hr = (p + (longint'(1) << 29)) >>> HR_SHIFT;
      else hr = -(((-p) + (longint'(1) << 29)) >>> HR_SHIFT);
      for (int k = 0; k < NUM_MODULES; k++) begin
         vx = (k >= 2) ? x - hr : x + hr;
         vy = (k == 1 || k == 2) ? y - hr : y + hr;
         neg[k] = (vy < 0);
         if (neg[k]) begin
            vx = -vx;
            vy = -vy;
         end
         sq    = vx * vx + vy * vy;
         mg[k] = root_floor(longint'(sq) << (2 * MAG_EXTRA));
         ang[k] = (400 * sq < (longint'(1) << (2 * FB))) ? 0 : heading_q16(vx, vy);
         if (sq > maxsq) begin
            maxsq  = sq;
            maxmag = mg[k];
         end
      end
      norm = maxsq > (longint'(1) << (2 * FB));
      for (int k = 0; k < NUM_MODULES; k++) begin
         if (norm && maxmag != 0) s = (SPEED_MAX * mg[k]) / maxmag;
         else s = (SPEED_MAX * mg[k]) >>> (FB + MAG_EXTRA);
         if (s > SPEED_MAX) s = SPEED_MAX;
         res.speed[k] = SPEED_W'(neg[k] ? -s : s);
         a = ang[k] + (longint'(trim_deg[k]) <<< ANG_FRAC);
         a = (a >= 0) ? (a >>> ANG_FRAC) : -((-a) >>> ANG_FRAC);
         res.angle[k] = ANGLE_W'(a);
      end
      return res;
   endfunction

   assign pending = wheel_q.size();

   always @(posedge clock) begin
      wheel_cmd_type want;
      logic signed [SPEED_W-1:0] got_s [NUM_MODULES];
      logic signed [ANGLE_W-1:0] got_a [NUM_MODULES];
      int nerr;
      nerr = 0;
      if (reset) begin
         for (int k = 0; k < NUM_MODULES; k++) trim_deg[k] <= '0;
         wheel_q.delete();
         errors <= 0;
      end else begin
         if (req_valid && !req_stall)
            wheel_q.push_back(solve_wheels(req_strafe_cmd, req_forward_cmd, req_turn_cmd));
         if (rsp_valid && !rsp_stall) begin
            got_s = '{rsp_drive_speed_a, rsp_drive_speed_b, rsp_drive_speed_c,
                      rsp_drive_speed_d};
            got_a = '{rsp_steer_angle_a, rsp_steer_angle_b, rsp_steer_angle_c,
                      rsp_steer_angle_d};
            if (wheel_q.size() == 0) begin
               $display("%0t: result beat with nothing expected", $time);
               nerr = nerr + 1;
            end else begin
               want = wheel_q.pop_front();
               for (int k = 0; k < NUM_MODULES; k++) begin
                  if (got_s[k] !== want.speed[k]) begin
                     $display("%0t: speed %0d expected %0d actual %0d", $time, k,
                              want.speed[k], got_s[k]);
                     nerr = nerr + 1;
                  end
                  if (got_a[k] !== want.angle[k]) begin
                     $display("%0t: angle %0d expected %0d actual %0d", $time, k,
                              want.angle[k], got_a[k]);
                     nerr = nerr + 1;
                  end
               end
            end
         end
         errors <= errors + nerr;
         if (csr_valid && csr_ready) trim_deg[csr_index] <= csr_data;
      end
   end

endmodule

[test/tb_swerve_module_kinematics.sv]
// Top of the swerve kinematics testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_swerve_module_kinematics;

   localparam int CMD_W       = swmk_pkg::CMD_W;
   localparam int SPEED_W     = swmk_pkg::SPEED_W;
   localparam int ANGLE_W     = swmk_pkg::ANGLE_W;
   localparam int CSR_IDX_W   = swmk_pkg::CSR_IDX_W;
   localparam int TRIM_W      = swmk_pkg::TRIM_W;
   localparam int NUM_MODULES = swmk_pkg::NUM_MODULES;

   localparam int PIPE_WAIT  = 60;    // beyond the pipe depth
   localparam int HANG_LIMIT = 3000;  // idle cycles tolerated, covers the long hold-off
   localparam int HOLD_LEN   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CMD_W-1:0] req_strafe_cmd = '0;
   logic signed [CMD_W-1:0] req_forward_cmd = '0;
   logic signed [CMD_W-1:0] req_turn_cmd = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SPEED_W-1:0] rsp_drive_speed_a, rsp_drive_speed_b;
   logic signed [SPEED_W-1:0] rsp_drive_speed_c, rsp_drive_speed_d;
   logic signed [ANGLE_W-1:0] rsp_steer_angle_a, rsp_steer_angle_b;
   logic signed [ANGLE_W-1:0] rsp_steer_angle_c, rsp_steer_angle_d;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = swmk_pkg::CSR_TRIM_A;
   logic signed [TRIM_W-1:0] csr_data = '0;

   int  pending, errors;
   bit  no_gaps = 1'b0;    // long stretch with both sides always willing
   bit  hold_req = 1'b0;   // ask the receiver for its one long hold-off
   bit  hold_used = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   swerve_module_kinematics i_dut (.*);

   swmk_checker i_checker (.*);

   // Receiver: random stalls, plus one long hold-off counted here so the pipe
   // fills and backs up into req_stall while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 15);
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Offer one command beat, with an optional random gap first; hold it until taken.
   task automatic send_cmd(input logic signed [CMD_W-1:0] x, input logic signed [CMD_W-1:0] y,
                           input logic signed [CMD_W-1:0] r);
      while (!no_gaps && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_strafe_cmd  <= x;
      req_forward_cmd <= y;
      req_turn_cmd    <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait for every expected result plus PIPE_WAIT, more than the pipe depth.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic write_trim(input logic [CSR_IDX_W-1:0] idx, input logic signed [TRIM_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of command shapes: full 16-bit noise, nominal range, dead band, axes.
   function automatic logic signed [CMD_W-1:0] pick_cmd;
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1:    return CMD_W'($urandom);
         2, 3, 4: return CMD_W'($urandom_range(0, 32768) - 16384);
         5:       return CMD_W'($urandom_range(0, 1600) - 800);
         6:       return '0;
         7:       return CMD_W'($urandom_range(0, 1) ? 16384 : -16384);
         default: return CMD_W'($urandom_range(0, 16384) - 8192);
      endcase
   endfunction

   initial begin
      logic signed [TRIM_W-1:0] trims [NUM_MODULES];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vector, extremes, pure axes, pure turn, folding,
      // exact +-90, dead band edge and heavy normalization.
      send_cmd(0, 0, 0);
      send_cmd(16384, 0, 0);
      send_cmd(-16384, 0, 0);
      send_cmd(0, 16384, 0);
      send_cmd(0, -16384, 0);
      send_cmd(0, 0, 16384);
      send_cmd(0, 0, -16384);
      send_cmd(16384, 16384, 16384);
      send_cmd(-16384, -16384, -16384);
      send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
      send_cmd(16'sh7FFF, 16'sh8000, 0);
      send_cmd(819, 0, 0);
      send_cmd(820, 0, 0);
      send_cmd(0, 818, 0);
      send_cmd(400, 300, 0);
      send_cmd(-5000, -100, 0);
      send_cmd(3000, -4000, 2000);
      send_cmd(0, 0, 1);
      send_cmd(-1, -1, -1);
      send_cmd(16'sh5555, 16'shAAAA, 16'sh5555);
      send_cmd(16'shAAAA, 16'sh5555, 16'shAAAA);
      drain();

      // Phases: each rewrites all trims, then runs random commands.
      for (int ph = 0; ph < 6; ph++) begin
         for (int k = 0; k < NUM_MODULES; k++) begin
            case (ph)
               0:       trims[k] = TRIM_W'(180);
               1:       trims[k] = TRIM_W'(-180);
               2:       trims[k] = TRIM_W'((k % 2) ? -256 : 255);
               3:       trims[k] = '0;
               default: trims[k] = TRIM_W'($urandom_range(0, 360) - 180);
            endcase
         end
         write_trim(swmk_pkg::CSR_TRIM_A, trims[0]);
         write_trim(swmk_pkg::CSR_TRIM_B, trims[1]);
         write_trim(swmk_pkg::CSR_TRIM_C, trims[2]);
         write_trim(swmk_pkg::CSR_TRIM_D, trims[3]);
         no_gaps = (ph == 3);
         for (int n = 0; n < 280; n++) begin
            if (ph == 1 && n == 50) hold_req <= 1'b1;
            // Pause the sender until every outstanding result is back.
            if (ph == 2 && n == 100) drain();
            send_cmd(pick_cmd(), pick_cmd(), pick_cmd());
         end
         drain();
      end

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/swmk_pkg.sv
design/swerve_module_kinematics.sv
test/swmk_checker.sv
test/tb_swerve_module_kinematics.sv
